/* hdl/itoa_pkg.sv */
package itoa_pkg;

    typedef enum logic [2:0] {
        FN_CHAR = 3'd0,
        FN_UDEC = 3'd1,
        FN_SDEC = 3'd2,
        FN_OCT  = 3'd3,
        FN_HEX  = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAW,
        ST_CONV,
        ST_SKIP,
        ST_PRE,
        ST_DIG,
        ST_SPACE
    } state_t;

    localparam int unsigned NDIG     = 11;          // octal of 32 bits needs 11 digits
    localparam int unsigned DIG_W    = 4 * NDIG;
    localparam int unsigned VAL_W    = 32;
    localparam int unsigned NDIG_W   = 4;
    localparam int unsigned BITCNT_W = 5;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // 0-9 then A-F
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else begin
            c = CH_UPA + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

    // true when every nibble is a valid BCD digit
    function automatic logic bcd_ok(input logic [DIG_W-1:0] v);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < NDIG; i++) begin
            if (v[4*i +: 4] > 4'd9) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

/* hdl/integer_to_ascii_radix_formatter_core.sv */
// Integer-to-ASCII formatter.
// Input channel (s_valid/s_ready, s_func, s_value) takes one word: a format
// code and a 32-bit value. Output channel (m_valid/m_ready, m_text_char,
// m_last) returns the text one character per word, m_last on the final one.
// Formats: raw byte, unsigned decimal, signed decimal ('-' prefix), octal
// ('0' prefix), hex ("0x" prefix, upper case). Numeric forms end in a space.
// Unused format codes are taken and dropped with no output.
// Steps per word, one word in flight at a time:
//   raw byte: the word is taken, then the character is sent.
//   decimal: shift-add-3 conversion, one value bit per cycle, then the
//   skip phase drops leading zeros, one per cycle, then the characters
//   go out one per cycle while the receiver keeps up (up to 12). Skipped
//   zeros and digits always add up to 11. Octal and hex skip the conversion:
//   their digits are the value's bit groups, loaded as the word is taken.
// The last character sits in the output register while the next word is
// taken, so a slow receiver overlaps with the start of the next value.
// A stalled receiver holds the character; conversion runs on, output waits.
// Reset (aresetn, synchronous, low) returns to idle and drops any output.
module integer_to_ascii_radix_formatter_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_func,
    input  logic [itoa_pkg::VAL_W-1:0]  s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_text_char,
    output logic                        m_last
);
    import itoa_pkg::*;

    state_t               state_reg, state_next;
    func_t                func_reg, func_next;
    logic                 neg_reg, neg_next;
    logic                 pre_reg, pre_next;          // hex prefix position
    logic [BITCNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [NDIG_W-1:0]    ndig_reg, ndig_next;        // digits still in dig_reg
    logic [VAL_W-1:0]     bin_reg, bin_next;
    logic [DIG_W-1:0]     dig_reg, dig_next;
    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           m_char_reg, m_char_next;
    logic                 m_last_reg, m_last_next;

    logic                 out_free;
    logic [VAL_W:0]       val_ext;
    logic [DIG_W-1:0]     oct_dig, hex_dig, dab_dig;
    logic [3:0]           top_dig;

    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_text_char = m_char_reg;
    assign m_last      = m_last_reg;
    assign top_dig     = dig_reg[DIG_W-1 -: 4];
    assign val_ext     = {1'b0, s_value};

    // octal/hex digits straight from bit groups; shift-add-3 correction
    always_comb begin
        oct_dig = '0;
        hex_dig = '0;
        dab_dig = dig_reg;
        for (int i = 0; i < NDIG; i++) begin
            oct_dig[4*i +: 4] = {1'b0, val_ext[3*i +: 3]};
            if (dig_reg[4*i +: 4] > 4'd4) begin
                dab_dig[4*i +: 4] = dig_reg[4*i +: 4] + 4'd3;
            end
        end
        hex_dig[VAL_W-1:0] = s_value;
    end

    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        neg_next     = neg_reg;
        pre_next     = pre_reg;
        bit_cnt_next = bit_cnt_reg;
        ndig_next    = ndig_reg;
        bin_next     = bin_reg;
        dig_next     = dig_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next    = func_t'(s_func);
                    neg_next     = (s_func == FN_SDEC) && s_value[VAL_W-1];
                    pre_next     = 1'b0;
                    bit_cnt_next = '0;
                    ndig_next    = NDIG_W'(NDIG);
                    bin_next     = s_value;
                    dig_next     = '0;
                    case (s_func)
                        FN_CHAR: state_next = ST_RAW;
                        FN_UDEC: state_next = ST_CONV;
                        FN_SDEC: begin
                            if (s_value[VAL_W-1]) begin
                                bin_next = '0 - s_value;
                            end
                            state_next = ST_CONV;
                        end
                        FN_OCT: begin
                            dig_next   = oct_dig;
                            state_next = ST_SKIP;
                        end
                        FN_HEX: begin
                            dig_next   = hex_dig;
                            state_next = ST_SKIP;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RAW: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = bin_reg[7:0];
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_CONV: begin
                dig_next     = {dab_dig[DIG_W-2:0], bin_reg[VAL_W-1]};
                bin_next     = {bin_reg[VAL_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BITCNT_W'(VAL_W - 1)) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_dig == 4'd0 && ndig_reg > NDIG_W'(1)) begin
                    dig_next  = {dig_reg[DIG_W-5:0], 4'd0};
                    ndig_next = ndig_reg - 1'b1;
                end else if (func_reg == FN_UDEC || (func_reg == FN_SDEC && !neg_reg)) begin
                    state_next = ST_DIG;
                end else begin
                    state_next = ST_PRE;
                end
            end
            ST_PRE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b0;
                    state_next   = ST_DIG;
                    case (func_reg)
                        FN_SDEC: m_char_next = CH_MINUS;
                        FN_HEX: begin
                            m_char_next = pre_reg ? CH_X : CH_ZERO;
                            pre_next    = 1'b1;
                            if (!pre_reg) begin
                                state_next = ST_PRE;
                            end
                        end
                        default: m_char_next = CH_ZERO;
                    endcase
                end
            end
            ST_DIG: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = digit_char(top_dig);
                    m_last_next  = 1'b0;
                    dig_next     = {dig_reg[DIG_W-5:0], 4'd0};
                    ndig_next    = ndig_reg - 1'b1;
                    if (ndig_reg == NDIG_W'(1)) begin
                        state_next = ST_SPACE;
                    end
                end
            end
            ST_SPACE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = CH_SPACE;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        neg_reg     <= neg_next;
        pre_reg     <= pre_next;
        bit_cnt_reg <= bit_cnt_next;
        ndig_reg    <= ndig_next;
        bin_reg     <= bin_next;
        dig_reg     <= dig_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

    a_dig_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIG) |-> (ndig_reg != '0))
        else $error("digit phase with no digits left");

    a_bcd_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV) |-> bcd_ok(dig_reg))
        else $error("conversion holds a non-decimal digit");

    a_bad_func: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_func > FN_HEX) |=> (state_reg == ST_IDLE))
        else $error("unused format code started work");

    a_space_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SPACE && out_free) |=> (m_valid && m_last && m_text_char == CH_SPACE))
        else $error("trailing space not sent as last word");

endmodule

/* tb/tb_integer_to_ascii_radix_formatter_core.sv */
`timescale 1ns / 100ps

module tb_integer_to_ascii_radix_formatter_core;
    import itoa_pkg::*;

    // One character word on the text channel, as the model expects it
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_word_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_func;
    logic [31:0] s_value;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_text_char;
    logic        m_last;

    // Characters still owed by the block, oldest first
    text_word_t expected_text[$];

    int src_idle_pct  = 0;  // chance per cycle that the sender holds off
    int snk_stall_pct = 0;  // chance per cycle that the receiver stalls
    int err_cnt       = 0;
    int n_values      = 0;  // accepted value words, unused codes included
    int n_chars       = 0;  // character words checked

    integer_to_ascii_radix_formatter_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_last      (m_last)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Text predictor
    // ------------------------------------------------------------------

    // ASCII glyph of one digit, 0-9 then upper-case A-F
    function automatic logic [7:0] glyph_of(input logic [31:0] d);
        if (d < 32'd10) begin
            return CH_ZERO + d[7:0];
        end else begin
            return CH_UPA + d[7:0] - 8'd10;
        end
    endfunction

    // Builds the text that one value word must produce and queues it.
    // Unused format codes produce nothing at all.
    function automatic void predict_text(input logic [2:0] fmt, input logic [31:0] val);
        logic [7:0]  txt[$];
        logic [7:0]  digs[$];
        logic [31:0] mag;
        logic [31:0] radix;
        mag   = val;
        radix = 32'd10;
        case (fmt)
            FN_CHAR: begin
                // raw byte only, no trailing space
                txt.push_back(val[7:0]);
            end
            FN_UDEC, FN_SDEC, FN_OCT, FN_HEX: begin
                if (fmt == FN_SDEC && val[31]) begin
                    // magnitude as unsigned 32 bits, so 0x80000000 stays whole
                    txt.push_back(CH_MINUS);
                    mag = 32'd0 - val;
                end
                if (fmt == FN_OCT) begin
                    txt.push_back(CH_ZERO);
                    radix = 32'd8;
                end
                if (fmt == FN_HEX) begin
                    txt.push_back(CH_ZERO);
                    txt.push_back(CH_X);
                    radix = 32'd16;
                end
                // zero still yields one digit
                do begin
                    digs.push_front(glyph_of(mag % radix));
                    mag = mag / radix;
                end while (mag != 32'd0);
                foreach (digs[k]) txt.push_back(digs[k]);
                txt.push_back(CH_SPACE);
            end
            default: ;
        endcase
        foreach (txt[i]) expected_text.push_back({txt[i], i == txt.size() - 1});
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Sends one value word. Entered and left at a falling edge; valid is
    // only dropped for a sender gap, never between back-to-back words.
    task automatic send_word(input logic [2:0] fmt, input logic [31:0] val);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= fmt;
        s_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_text(fmt, val);
        n_values++;
        @(negedge aclk);
    endtask

    // Receiver back-pressure, re-rolled every cycle
    always @(negedge aclk) begin
        m_ready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);
    end

    // ------------------------------------------------------------------
    // Text checker: every accepted character word against the oldest owed
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        text_word_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            n_chars++;
            if (expected_text.size() == 0) begin
                $error("unexpected text word: text_char %h last %b", m_text_char, m_last);
                err_cnt++;
            end else begin
                exp_w = expected_text.pop_front();
                if (m_text_char !== exp_w.ch) begin
                    $error("text_char: expected %h, got %h", exp_w.ch, m_text_char);
                    err_cnt++;
                end
                if (m_last !== exp_w.last) begin
                    $error("last: expected %b, got %b", exp_w.last, m_last);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Raw byte: upper value bits must be dropped
    task automatic test_raw_char();
        send_word(FN_CHAR, 32'h0000_0000);
        send_word(FN_CHAR, 32'h0000_00FF);
        send_word(FN_CHAR, 32'hFFFF_FF41);
    endtask

    // Unsigned decimal, full 32 bits, no 16-bit truncation
    task automatic test_unsigned_decimal();
        send_word(FN_UDEC, 32'd0);
        send_word(FN_UDEC, 32'd9);
        send_word(FN_UDEC, 32'd10);
        send_word(FN_UDEC, 32'd65536);
        send_word(FN_UDEC, 32'hFFFF_FFFF);
    endtask

    // Signed decimal, including the most negative value
    task automatic test_signed_decimal();
        send_word(FN_SDEC, 32'd0);
        send_word(FN_SDEC, 32'hFFFF_FFFF);
        send_word(FN_SDEC, 32'h8000_0000);
        send_word(FN_SDEC, 32'h7FFF_FFFF);
    endtask

    // Octal up to the 13-character text; hex checks digit order D/E
    task automatic test_octal_hex();
        send_word(FN_OCT, 32'd0);
        send_word(FN_OCT, 32'h3FFF_FFFF);
        send_word(FN_OCT, 32'hFFFF_FFFF);
        send_word(FN_HEX, 32'd0);
        send_word(FN_HEX, 32'hFFFF_FFFF);
        send_word(FN_HEX, 32'hABCD_EF09);
    endtask

    // Codes 5..7 are swallowed; a following word must still come out right
    task automatic test_unused_codes();
        send_word(3'd5, 32'h1234_5678);
        send_word(3'd6, 32'hFFFF_FFFF);
        send_word(3'd7, 32'h0000_0000);
        send_word(FN_CHAR, 32'h0000_005A);
    endtask

    // Values biased toward digit-count and sign boundaries
    function automatic logic [31:0] pick_value();
        logic [31:0] pw;
        logic [31:0] v;
        pw = 32'd1;
        case ($urandom_range(5))
            0: v = $urandom;
            1: v = $urandom_range(99);
            2: v = $urandom >> $urandom_range(31);
            3: v = 32'd0 - $urandom_range(1000);
            4: begin
                case ($urandom_range(5))
                    0: v = 32'h0000_0000;
                    1: v = 32'hFFFF_FFFF;
                    2: v = 32'h8000_0000;
                    3: v = 32'h7FFF_FFFF;
                    4: v = 32'h4000_0000;
                    default: v = 32'h3FFF_FFFF;
                endcase
            end
            default: begin
                // either side of a power of ten
                repeat ($urandom_range(9)) pw = pw * 32'd10;
                v = pw - $urandom_range(1);
            end
        endcase
        return v;
    endfunction

    // Random words under one pressure setting; unused codes come as noise
    // and do not count toward n_items
    task automatic test_random_stream(input int n_items, input int src_pct, input int snk_pct);
        int          n_done;
        logic [2:0]  fmt;
        logic [31:0] val;
        n_done        = 0;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        while (n_done < n_items) begin
            if ($urandom_range(9) == 0) begin
                fmt = 3'($urandom_range(7, 5));
            end else begin
                fmt = 3'($urandom_range(4));
                n_done++;
            end
            val = pick_value();
            send_word(fmt, val);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func  = FN_CHAR;
        s_value = 32'd0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed words, no pressure
        test_raw_char();
        test_unsigned_decimal();
        test_signed_decimal();
        test_octal_hex();
        test_unused_codes();

        // random words across the pressure phases
        test_random_stream(45, 0, 0);
        test_random_stream(45, 48, 0);
        test_random_stream(45, 0, 48);
        test_random_stream(45, 7, 7);

        s_valid <= 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;

        // drain, then cover the slowest decimal conversion for strays
        while (expected_text.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);

        $display("formatted %0d value words into %0d checked characters", n_values, n_chars);
        $display("covered raw, decimal, signed, octal, hex and unused codes under 4 pressures");
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial begin
        #5000000;
        $display("timeout with %0d characters owed", expected_text.size());
        $display("status: fail");
        $finish;
    end

endmodule
